### rtl/core/dpdpc_pkg.sv
// Shared constants for the PD controller: widths, indexes, mode codes, reset values.
package dpdpc_pkg;

	// Width of the configuration write data bus.
	localparam int CFG_DATA_W = 32;
	// Width of the configuration register index.
	localparam int CFG_INDEX_W = 3;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_MODE    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_REVERSE = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_TARGET  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_CAP     = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_KP      = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_KD      = 3'd6;

	// Motion mode codes; the unused code behaves as a straight move.
	localparam logic [1:0] MODE_STRAIGHT = 2'd0;
	localparam logic [1:0] MODE_TURN     = 2'd1;
	localparam logic [1:0] MODE_STRAFE   = 2'd2;

	// Register reset values.
	localparam logic [6:0]  CAP_RESET = 7'd127;
	localparam logic [15:0] KP_RESET  = 16'd179;
	localparam logic [15:0] KD_RESET  = 16'd282;

endpackage

### rtl/core/drive_pd_position_controller_core.sv
// PD position controller with output clamp for a four-motor drive.
//
// Usage: one word on the input channel carries a sample: a start flag, the
// millisecond time and the left and right encoder positions. Each accepted
// word produces exactly one result word on the output channel: an active flag
// and four signed motor powers. Both channels use valid/stall; a word moves at
// a rising edge with valid high and stall low.
// Configuration registers are written through wr_en/wr_index/wr_data; the
// user must write them only while the block is idle, which the block itself
// does not enforce. Writes to unknown indexes are ignored. Throughput is one
// word per clock while the receiver does not stall; a word passes the input,
// product and result registers. The remembered error and start references
// are updated as a word leaves the input register, for the next word to see.
// When the receiver stalls, the result register holds and the stall walks
// back stage by stage; in_stall rises only when every stage is occupied.
// Reset clears all pipeline valids, the references, the start time and the
// remembered error, and loads the register reset values (cap 127, kp 179,
// kd 282, all others zero).
module drive_pd_position_controller_core
	import dpdpc_pkg::*;
#(
	parameter int GAIN_FRACTION_BITS = 8,
	parameter int POSITION_BITS      = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration write port
	input  logic                            wr_en,
	input  logic [CFG_INDEX_W-1:0]          wr_index,
	input  logic [CFG_DATA_W-1:0]           wr_data,
	// Input channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            start_req,
	input  logic [31:0]                     time_ms,
	input  logic signed [POSITION_BITS-1:0] left_position,
	input  logic signed [POSITION_BITS-1:0] right_position,
	// Output channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            active,
	output logic signed [7:0]               left_back_power,
	output logic signed [7:0]               left_front_power,
	output logic signed [7:0]               right_back_power,
	output logic signed [7:0]               right_front_power
);

	localparam int P      = POSITION_BITS;
	localparam int ERR_W  = P + 2;
	localparam int DERR_W = P + 3;
	localparam int PP_W   = ERR_W + 17;
	localparam int PD_W   = DERR_W + 17;
	localparam int SUM_W  = PD_W + 1;
	localparam logic [SUM_W-1:0] TRUNC_BIAS =
		SUM_W'((64'd1 << GAIN_FRACTION_BITS) - 64'd1);

	// Configuration registers
	logic [1:0]          mode_q;
	logic                reverse_q;
	logic signed [P-1:0] target_q;
	logic [31:0]         timeout_q;
	logic [6:0]          cap_q;
	logic [15:0]         kp_q;
	logic [15:0]         kd_q;

	// Controller state
	logic signed [ERR_W-1:0] last_error_q;
	logic [31:0]             start_time_q;
	logic signed [P-1:0]     left_ref_q;
	logic signed [P-1:0]     right_ref_q;

	// Input register stage
	logic                valid_s1;
	logic                start_s1;
	logic [31:0]         time_s1;
	logic signed [P-1:0] left_s1;
	logic signed [P-1:0] right_s1;

	// Product register stage
	logic                   valid_s2;
	logic                   act_s2;
	logic signed [PP_W-1:0] prod_p_s2;
	logic signed [PD_W-1:0] prod_d_s2;

	// Result register
	logic       out_valid_q;
	logic       active_q;
	logic signed [7:0] lb_q, lf_q, rb_q, rf_q;

	// Flow control
	logic out_free, s2_free, s1_adv, in_take;

	assign out_free = !out_valid_q || !out_stall;
	assign s2_free  = !valid_s2 || out_free;
	assign s1_adv   = valid_s1 && s2_free;
	assign in_stall = valid_s1 && !s2_free;
	assign in_take  = in_valid && !in_stall;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_STRAIGHT;
			reverse_q <= 1'b0;
			target_q  <= '0;
			timeout_q <= '0;
			cap_q     <= CAP_RESET;
			kp_q      <= KP_RESET;
			kd_q      <= KD_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_MODE:    mode_q    <= wr_data[1:0];
				REG_REVERSE: reverse_q <= wr_data[0];
				REG_TARGET:  target_q  <= wr_data[P-1:0];
				REG_TIMEOUT: timeout_q <= wr_data[31:0];
				REG_CAP:     cap_q     <= wr_data[6:0];
				REG_KP:      kp_q      <= wr_data[15:0];
				REG_KD:      kd_q      <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s2_free || !valid_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			start_s1 <= start_req;
			time_s1  <= time_ms;
			left_s1  <= left_position;
			right_s1 <= right_position;
		end
	end

	// Stage one: references, elapsed time, error and the two gain products.
	logic [31:0]             st_eff, elapsed;
	logic signed [P-1:0]     lref_eff, rref_eff;
	logic signed [ERR_W-1:0] le_eff, pos, err;
	logic signed [P:0]       ldiff, rdiff, dsel;
	logic signed [DERR_W-1:0] derr;
	logic signed [16:0]      kp_s, kd_s;
	logic signed [PP_W-1:0]  prod_p;
	logic signed [PD_W-1:0]  prod_d;
	logic                    act;
	logic                    turn;

	always_comb begin
		turn     = (mode_q == MODE_TURN);
		st_eff   = start_s1 ? time_s1 : start_time_q;
		lref_eff = start_s1 ? left_s1 : left_ref_q;
		rref_eff = start_s1 ? right_s1 : right_ref_q;
		le_eff   = start_s1 ? '0 : last_error_q;
		elapsed  = time_s1 - st_eff;
		act      = (elapsed < timeout_q);
		ldiff    = {left_s1[P-1], left_s1} - {lref_eff[P-1], lref_eff};
		rdiff    = {right_s1[P-1], right_s1} - {rref_eff[P-1], rref_eff};
		dsel     = (turn && reverse_q) ? rdiff : ldiff;
		// Turn mode works on the distance magnitude.
		if (turn && dsel[P]) begin
			pos = -{dsel[P], dsel};
		end else begin
			pos = {dsel[P], dsel};
		end
		err    = {{2{target_q[P-1]}}, target_q} - pos;
		derr   = {err[ERR_W-1], err} - {le_eff[ERR_W-1], le_eff};
		kp_s   = {1'b0, kp_q};
		kd_s   = {1'b0, kd_q};
		prod_p = PP_W'(kp_s) * PP_W'(err);
		prod_d = PD_W'(kd_s) * PD_W'(derr);
	end

	// Controller state updates as a word leaves stage one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_error_q <= '0;
			start_time_q <= '0;
			left_ref_q   <= '0;
			right_ref_q  <= '0;
		end else if (s1_adv) begin
			if (start_s1) begin
				start_time_q <= time_s1;
				left_ref_q   <= left_s1;
				right_ref_q  <= right_s1;
			end
			if (act) begin
				last_error_q <= err;
			end else if (start_s1) begin
				last_error_q <= '0;
			end
		end
	end

	// Product register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			act_s2    <= act;
			prod_p_s2 <= prod_p;
			prod_d_s2 <= prod_d;
		end
	end

	// Stage two: sum, scale toward zero, clamp and motor signs.
	logic signed [SUM_W-1:0] sum, sum_b, scaled, cap_w;
	logic signed [7:0]       pwr, dpwr, npwr;
	logic signed [7:0]       lb_d, lf_d, rb_d, rf_d;

	always_comb begin
		sum    = {{2{prod_p_s2[PP_W-1]}}, prod_p_s2} + {prod_d_s2[PD_W-1], prod_d_s2};
		sum_b  = sum[SUM_W-1] ? (sum + $signed(TRUNC_BIAS)) : sum;
		scaled = sum_b >>> GAIN_FRACTION_BITS;
		cap_w  = $signed({{(SUM_W-7){1'b0}}, cap_q});
		if (scaled > cap_w) begin
			pwr = {1'b0, cap_q};
		end else if (scaled < -cap_w) begin
			pwr = -$signed({1'b0, cap_q});
		end else begin
			pwr = scaled[7:0];
		end
		dpwr = reverse_q ? -pwr : pwr;
		npwr = -dpwr;
		case (mode_q)
			MODE_TURN: begin
				lb_d = npwr; lf_d = npwr; rb_d = dpwr; rf_d = dpwr;
			end
			MODE_STRAFE: begin
				lb_d = npwr; lf_d = dpwr; rb_d = dpwr; rf_d = npwr;
			end
			default: begin
				lb_d = dpwr; lf_d = dpwr; rb_d = dpwr; rf_d = dpwr;
			end
		endcase
		// Outside the active window every command is zero.
		if (!act_s2) begin
			lb_d = '0; lf_d = '0; rb_d = '0; rf_d = '0;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && out_free) begin
			active_q <= act_s2;
			lb_q     <= lb_d;
			lf_q     <= lf_d;
			rb_q     <= rb_d;
			rf_q     <= rf_d;
		end
	end

	assign out_valid         = out_valid_q;
	assign active            = active_q;
	assign left_back_power   = lb_q;
	assign left_front_power  = lf_q;
	assign right_back_power  = rb_q;
	assign right_front_power = rf_q;

	// An inactive word carries no drive.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !active |-> left_back_power == 8'sd0 && left_front_power == 8'sd0
			&& right_back_power == 8'sd0 && right_front_power == 8'sd0)
		else $error("inactive word carries nonzero power");

	// The left back command stays within the cap.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> left_back_power <= $signed({1'b0, cap_q})
			&& left_back_power >= -$signed({1'b0, cap_q}))
		else $error("power exceeds cap");

	// Turn mode drives the two sides in opposition.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode_q == MODE_TURN |-> left_back_power == left_front_power
			&& right_back_power == right_front_power
			&& left_back_power == -right_back_power)
		else $error("turn mode sides not opposed");

	// Straight moves drive all four motors alike.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode_q != MODE_TURN && mode_q != MODE_STRAFE
			|-> left_back_power == right_front_power && left_front_power == right_back_power
			&& left_back_power == left_front_power)
		else $error("straight mode powers differ");

	// The input only stalls when the whole pipe is full and blocked.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_valid_q && out_stall)
		else $error("input stalled with room in the pipe");

endmodule
